@@ rtl/core/gfr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph renderer package
// Shared constants, codes, types and the pixel mask function of the framebuffer glyph renderer.
// ----------------------------------------------------------------------------
package gfr_pkg;

   localparam int GLYPH_COUNT   = 256;
   localparam int GLYPH_ROWS    = 16;
   localparam int GLYPH_COLUMNS = 8;

   localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int ROW_W       = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

   localparam int ADDR_W   = 64;
   localparam int COLOR_W  = 32;
   localparam int LINE_W   = 16;
   localparam int POS_W    = 16;
   localparam int BPP_W    = 6;
   localparam int BYTES_W  = 3;
   localparam int STRIDE_W = LINE_W + BYTES_W;
   localparam int CODE_W   = 8;
   localparam int GROW_W   = 4;
   localparam int FONT_W   = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [ADDR_W-1:0] FRAME_BASE_RESET = '0;
   localparam logic [BPP_W-1:0]  BPP_RESET        = 6'd32;
   localparam logic [LINE_W-1:0] LINE_WIDTH_RESET = 16'd640;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_BASE     = 2'd0,
      CSR_BITS_PER_PIXEL = 2'd1,
      CSR_LINE_WIDTH     = 2'd2
   } csr_index_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_DRAW = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      OP_LINE,
      OP_SCALE,
      OP_STRIDE,
      OP_STEP
   } mac_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LINE,
      ST_SCALE,
      ST_STRIDE,
      ST_ROW
   } state_type;

   function automatic logic [COLOR_W-1:0] pixel_mask(input logic [BYTES_W-1:0] bytes);
      logic [COLOR_W-1:0] mask;
      case (bytes)
         3'd1:    mask = 32'h0000_00FF;
         3'd2:    mask = 32'h0000_FFFF;
         3'd3:    mask = 32'h00FF_FFFF;
         default: mask = 32'hFFFF_FFFF;
      endcase
      return mask;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/glyph_to_framebuffer_renderer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph to framebuffer renderer
// Renders 8x16 bitmap glyphs from a loadable font store into row transactions.
// ----------------------------------------------------------------------------
// A load transaction writes one font row. A draw transaction runs setup steps
// on the shared multiply-add unit (line offset, scaled start address, row
// stride), then emits one row per cycle while the result side accepts,
// sixteen rows in all, each address stepped by the same unit. The next
// transaction is taken as soon as the last row sits in the output register.
// A draw with drawing disabled produces nothing. The font store is not
// cleared at reset; draw only glyph rows that were loaded.
module glyph_to_framebuffer_renderer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_action,
   input  wire logic [gfr_pkg::CODE_W-1:0]        req_glyph_code,
   input  wire logic [gfr_pkg::GROW_W-1:0]        req_glyph_row,
   input  wire logic [gfr_pkg::FONT_W-1:0]        req_row_bits,
   input  wire logic [gfr_pkg::POS_W-1:0]         req_x_pos,
   input  wire logic [gfr_pkg::POS_W-1:0]         req_y_pos,
   input  wire logic [gfr_pkg::COLOR_W-1:0]       req_fore_color,
   input  wire logic [gfr_pkg::COLOR_W-1:0]       req_back_color,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [gfr_pkg::ADDR_W-1:0]        rsp_row_address,
   output logic      [gfr_pkg::COLOR_W-1:0]       rsp_pixel_0,
   output logic      [gfr_pkg::COLOR_W-1:0]       rsp_pixel_1,
   output logic      [gfr_pkg::COLOR_W-1:0]       rsp_pixel_2,
   output logic      [gfr_pkg::COLOR_W-1:0]       rsp_pixel_3,
   output logic      [gfr_pkg::COLOR_W-1:0]       rsp_pixel_4,
   output logic      [gfr_pkg::COLOR_W-1:0]       rsp_pixel_5,
   output logic      [gfr_pkg::COLOR_W-1:0]       rsp_pixel_6,
   output logic      [gfr_pkg::COLOR_W-1:0]       rsp_pixel_7,
   output logic                                   rsp_last_row,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [gfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [gfr_pkg::ADDR_W-1:0]        csr_wdata
);
   import gfr_pkg::*;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]   frame_base_ff;
   logic [BPP_W-1:0]    bpp_ff;
   logic [LINE_W-1:0]   line_width_ff;
   logic [BYTES_W-1:0]  pixel_bytes;
   logic                draw_enabled;
   logic [COLOR_W-1:0]  color_mask;

   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [POS_W-1:0]    x_ff, y_ff;
   logic [CODE_W-1:0]   code_ff;
   logic                code_ok_ff;
   logic [COLOR_W-1:0]  fore_ff, back_ff;

   logic                capture;
   logic                load_rsp;
   logic                slot_free;
   logic                last;
   mac_op_type          mac_op;
   logic [ADDR_W-1:0]   mac_result;

   logic                wr_en;
   logic [STORE_AW-1:0] wr_addr;
   logic [STORE_AW-1:0] rd_addr;
   logic [FONT_W-1:0]   rd_data;
   logic [FONT_W-1:0]   font_row;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [COLOR_W-1:0]  pix_ff [GLYPH_COLUMNS];
   logic [COLOR_W-1:0]  pix_in [GLYPH_COLUMNS];
   logic                rsp_last_ff;

   assign pixel_bytes  = bpp_ff[BPP_W-1:3];
   assign draw_enabled = (frame_base_ff != '0) && (bpp_ff != '0) && (bpp_ff[2:0] == 3'd0);
   assign color_mask   = pixel_mask(pixel_bytes);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff <= FRAME_BASE_RESET;
         bpp_ff        <= BPP_RESET;
         line_width_ff <= LINE_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_BASE:     frame_base_ff <= csr_wdata;
            CSR_BITS_PER_PIXEL: bpp_ff        <= csr_wdata[BPP_W-1:0];
            CSR_LINE_WIDTH:     line_width_ff <= csr_wdata[LINE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign wr_en   = req_valid && req_ready && (req_action == ACT_LOAD)
                    && (int'(req_glyph_code) < GLYPH_COUNT)
                    && (int'(req_glyph_row) < GLYPH_ROWS);
   assign wr_addr = STORE_AW'(int'(req_glyph_code) * GLYPH_ROWS + int'(req_glyph_row));
   assign rd_addr = STORE_AW'(int'(code_ff) * GLYPH_ROWS + int'(row_in));

   gfr_font_store u_font_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (req_row_bits),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   gfr_mac u_mac (
      .op          (mac_op),
      .frame_base  (frame_base_ff),
      .line_width  (line_width_ff),
      .pixel_bytes (pixel_bytes),
      .x_pos       (x_ff),
      .y_pos       (y_ff),
      .addr        (addr_ff),
      .stride      (stride_ff),
      .result      (mac_result)
   );

   assign font_row  = code_ok_ff ? rd_data : '0;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last      = (row_ff == ROW_W'(GLYPH_ROWS - 1));

   always_comb begin
      for (int c = 0; c < GLYPH_COLUMNS; c++) begin
         pix_in[c] = font_row[GLYPH_COLUMNS-1-c] ? fore_ff : back_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      row_in       = '0;
      addr_in      = addr_ff;
      stride_in    = stride_ff;
      mac_op       = OP_STEP;
      capture      = 1'b0;
      load_rsp     = 1'b0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && (req_action == ACT_DRAW) && draw_enabled) begin
               capture  = 1'b1;
               state_in = ST_LINE;
            end
         end
         ST_LINE: begin
            mac_op   = OP_LINE;
            addr_in  = mac_result;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            mac_op   = OP_SCALE;
            addr_in  = mac_result;
            state_in = ST_STRIDE;
         end
         ST_STRIDE: begin
            mac_op    = OP_STRIDE;
            stride_in = mac_result[STRIDE_W-1:0];
            state_in  = ST_ROW;
         end
         ST_ROW: begin
            mac_op = OP_STEP;
            row_in = row_ff;
            if (slot_free) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               addr_in      = mac_result;
               if (last) begin
                  row_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      stride_ff <= stride_in;
      if (capture) begin
         x_ff       <= req_x_pos;
         y_ff       <= req_y_pos;
         code_ff    <= req_glyph_code;
         code_ok_ff <= (int'(req_glyph_code) < GLYPH_COUNT);
         fore_ff    <= req_fore_color & color_mask;
         back_ff    <= req_back_color & color_mask;
      end
      if (load_rsp) begin
         rsp_addr_ff <= addr_ff;
         rsp_last_ff <= last;
         for (int c = 0; c < GLYPH_COLUMNS; c++) begin
            pix_ff[c] <= pix_in[c];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row_address = rsp_addr_ff;
   assign rsp_pixel_0     = pix_ff[0];
   assign rsp_pixel_1     = pix_ff[1];
   assign rsp_pixel_2     = pix_ff[2];
   assign rsp_pixel_3     = pix_ff[3];
   assign rsp_pixel_4     = pix_ff[4];
   assign rsp_pixel_5     = pix_ff[5];
   assign rsp_pixel_6     = pix_ff[6];
   assign rsp_pixel_7     = pix_ff[7];
   assign rsp_last_row    = rsp_last_ff;

endmodule
`default_nettype wire

@@ rtl/core/gfr_font_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Glyph font store
// One write port and one registered read port over the glyph row bitmaps.
// ----------------------------------------------------------------------------
module gfr_font_store (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [gfr_pkg::STORE_AW-1:0]  wr_addr,
   input  wire logic [gfr_pkg::FONT_W-1:0]    wr_data,
   input  wire logic [gfr_pkg::STORE_AW-1:0]  rd_addr,
   output logic      [gfr_pkg::FONT_W-1:0]    rd_data_ff
);
   import gfr_pkg::*;

   logic [FONT_W-1:0] store_ff [STORE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/core/gfr_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Address multiply-add unit
// Shared multiply-add that builds the row addresses step by step.
// ----------------------------------------------------------------------------
module gfr_mac (
   input  wire gfr_pkg::mac_op_type              op,
   input  wire logic [gfr_pkg::ADDR_W-1:0]       frame_base,
   input  wire logic [gfr_pkg::LINE_W-1:0]       line_width,
   input  wire logic [gfr_pkg::BYTES_W-1:0]      pixel_bytes,
   input  wire logic [gfr_pkg::POS_W-1:0]        x_pos,
   input  wire logic [gfr_pkg::POS_W-1:0]        y_pos,
   input  wire logic [gfr_pkg::ADDR_W-1:0]       addr,
   input  wire logic [gfr_pkg::STRIDE_W-1:0]     stride,
   output logic      [gfr_pkg::ADDR_W-1:0]       result
);
   import gfr_pkg::*;

   logic [31:0]       mul_a;
   logic [15:0]       mul_b;
   logic [ADDR_W-1:0] add_c;
   logic [47:0]       prod;

   always_comb begin
      case (op)
         OP_LINE: begin
            mul_a = 32'(y_pos);
            mul_b = line_width;
            add_c = 64'(x_pos);
         end
         OP_SCALE: begin
            mul_a = addr[31:0];
            mul_b = 16'(pixel_bytes);
            add_c = frame_base;
         end
         OP_STRIDE: begin
            mul_a = 32'(line_width);
            mul_b = 16'(pixel_bytes);
            add_c = '0;
         end
         OP_STEP: begin
            mul_a = 32'(stride);
            mul_b = 16'd1;
            add_c = addr;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
            add_c = '0;
         end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign result = add_c + 64'(prod);

endmodule
`default_nettype wire

@@ bench/tb_glyph_to_framebuffer_renderer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph renderer testbench
// Loads glyph rows into the font store, draws glyphs under several register
// settings and checks every row transaction against a predicted row.
// ----------------------------------------------------------------------------
module tb_glyph_to_framebuffer_renderer;
   import gfr_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 32;
   localparam int RANDOM_ITEMS  = 160;
   localparam int PHASES        = 8;

   typedef struct packed {
      action_type                  action;
      logic [CODE_W-1:0]           code;
      logic [GROW_W-1:0]           row;
      logic [FONT_W-1:0]           bits;
      logic [POS_W-1:0]            x;
      logic [POS_W-1:0]            y;
      logic [COLOR_W-1:0]          fore;
      logic [COLOR_W-1:0]          back;
   } glyph_request_type;

   typedef struct packed {
      logic [ADDR_W-1:0]                     address;
      logic [GLYPH_COLUMNS-1:0][COLOR_W-1:0] pixel;
      logic                                  last;
   } glyph_row_type;

   class render_scoreboard;
      glyph_row_type     expected_rows[$];
      logic [FONT_W-1:0] font_rows [STORE_DEPTH];
      logic [ADDR_W-1:0] frame_base;
      logic [BPP_W-1:0]  pixel_bits;
      logic [LINE_W-1:0] line_width;
      int                errors;
      int                rows_checked;

      function new();
         frame_base   = FRAME_BASE_RESET;
         pixel_bits   = BPP_RESET;
         line_width   = LINE_WIDTH_RESET;
         errors       = 0;
         rows_checked = 0;
      endfunction

      function void note_config(csr_index_type idx, logic [ADDR_W-1:0] data);
         case (idx)
            CSR_FRAME_BASE:     frame_base = data;
            CSR_BITS_PER_PIXEL: pixel_bits = data[BPP_W-1:0];
            CSR_LINE_WIDTH:     line_width = data[LINE_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(glyph_request_type rq);
         logic [ADDR_W-1:0]  bytes;
         logic [COLOR_W-1:0] mask;
         logic [FONT_W-1:0]  bits;
         glyph_row_type      row;
         if (rq.action == ACT_LOAD) begin
            font_rows[int'(rq.code) * GLYPH_ROWS + int'(rq.row)] = rq.bits;
            return;
         end
         if (frame_base == '0 || pixel_bits == '0 || pixel_bits[2:0] != 3'd0)
            return;
         bytes = ADDR_W'(pixel_bits >> 3);
         mask  = (bytes >= 4) ? '1 : COLOR_W'((64'd1 << (8 * bytes)) - 64'd1);
         for (int r = 0; r < GLYPH_ROWS; r++) begin
            bits = font_rows[int'(rq.code) * GLYPH_ROWS + r];
            row.address = frame_base + (ADDR_W'(line_width) * (ADDR_W'(rq.y) + ADDR_W'(r))
                          + ADDR_W'(rq.x)) * bytes;
            for (int c = 0; c < GLYPH_COLUMNS; c++)
               row.pixel[c] = (bits[GLYPH_COLUMNS-1-c] ? rq.fore : rq.back) & mask;
            row.last = (r == GLYPH_ROWS - 1);
            expected_rows.push_back(row);
         end
      endfunction

      function void check_row(glyph_row_type got);
         glyph_row_type want;
         if (expected_rows.size() == 0) begin
            $display("%0t: unexpected row transaction, expected none, actual address %h",
                     $time, got.address);
            errors++;
            return;
         end
         want = expected_rows.pop_front();
         rows_checked++;
         if (got.address !== want.address) begin
            $display("%0t: row_address expected %h, actual %h", $time, want.address,
                     got.address);
            errors++;
         end
         for (int c = 0; c < GLYPH_COLUMNS; c++) begin
            if (got.pixel[c] !== want.pixel[c]) begin
               $display("%0t: pixel_%0d expected %h, actual %h", $time, c, want.pixel[c],
                        got.pixel[c]);
               errors++;
            end
         end
         if (got.last !== want.last) begin
            $display("%0t: last_row expected %b, actual %b", $time, want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   action_type           req_action = ACT_LOAD;
   logic [CODE_W-1:0]    req_glyph_code = '0;
   logic [GROW_W-1:0]    req_glyph_row = '0;
   logic [FONT_W-1:0]    req_row_bits = '0;
   logic [POS_W-1:0]     req_x_pos = '0;
   logic [POS_W-1:0]     req_y_pos = '0;
   logic [COLOR_W-1:0]   req_fore_color = '0;
   logic [COLOR_W-1:0]   req_back_color = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ADDR_W-1:0]    rsp_row_address;
   logic [COLOR_W-1:0]   rsp_pixel_0, rsp_pixel_1, rsp_pixel_2, rsp_pixel_3;
   logic [COLOR_W-1:0]   rsp_pixel_4, rsp_pixel_5, rsp_pixel_6, rsp_pixel_7;
   logic                 rsp_last_row;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_FRAME_BASE;
   logic [ADDR_W-1:0]    csr_wdata = '0;

   render_scoreboard     board;
   glyph_row_type        seen_row;
   bit                   steady_tail = 1'b0;
   int                   gap_odds = 0;
   int                   cycle_count = 0;
   int                   items_sent = 0;
   int                   draws_sent = 0;
   int                   loads_sent = 0;
   int                   settings_used = 0;
   bit                   row_loaded [STORE_DEPTH];
   bit                   is_drawable [GLYPH_COUNT];
   logic [CODE_W-1:0]    drawable[$];

   glyph_to_framebuffer_renderer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_glyph_code  (req_glyph_code),
      .req_glyph_row   (req_glyph_row),
      .req_row_bits    (req_row_bits),
      .req_x_pos       (req_x_pos),
      .req_y_pos       (req_y_pos),
      .req_fore_color  (req_fore_color),
      .req_back_color  (req_back_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_address (rsp_row_address),
      .rsp_pixel_0     (rsp_pixel_0),
      .rsp_pixel_1     (rsp_pixel_1),
      .rsp_pixel_2     (rsp_pixel_2),
      .rsp_pixel_3     (rsp_pixel_3),
      .rsp_pixel_4     (rsp_pixel_4),
      .rsp_pixel_5     (rsp_pixel_5),
      .rsp_pixel_6     (rsp_pixel_6),
      .rsp_pixel_7     (rsp_pixel_7),
      .rsp_last_row    (rsp_last_row),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #6 clock = ~clock;

   assign seen_row = {rsp_row_address, rsp_pixel_7, rsp_pixel_6, rsp_pixel_5, rsp_pixel_4,
                      rsp_pixel_3, rsp_pixel_2, rsp_pixel_1, rsp_pixel_0, rsp_last_row};

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_row(seen_row);
   end

   initial begin
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         if (!steady_tail && $urandom_range(0, 1) == 1) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   task automatic push_request(glyph_request_type rq);
      int first;
      bit complete;
      if (!steady_tail && $urandom_range(1, 4) <= gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= rq.action;
      req_glyph_code <= rq.code;
      req_glyph_row  <= rq.row;
      req_row_bits   <= rq.bits;
      req_x_pos      <= rq.x;
      req_y_pos      <= rq.y;
      req_fore_color <= rq.fore;
      req_back_color <= rq.back;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(rq);
      items_sent++;
      if (rq.action == ACT_LOAD) begin
         loads_sent++;
         first = int'(rq.code) * GLYPH_ROWS;
         row_loaded[first + int'(rq.row)] = 1'b1;
         complete = 1'b1;
         for (int r = 0; r < GLYPH_ROWS; r++)
            complete &= row_loaded[first + r];
         if (complete && !is_drawable[rq.code]) begin
            is_drawable[rq.code] = 1'b1;
            drawable.push_back(rq.code);
         end
      end else begin
         draws_sent++;
      end
   endtask

   function automatic glyph_request_type random_request(action_type act);
      glyph_request_type rq;
      rq.action = act;
      rq.code   = CODE_W'($urandom);
      rq.row    = GROW_W'($urandom);
      rq.bits   = FONT_W'($urandom);
      rq.x      = POS_W'($urandom);
      rq.y      = POS_W'($urandom);
      rq.fore   = $urandom;
      rq.back   = $urandom;
      return rq;
   endfunction

   task automatic load_row(logic [CODE_W-1:0] code, logic [GROW_W-1:0] row,
                           logic [FONT_W-1:0] bits);
      glyph_request_type rq;
      rq      = random_request(ACT_LOAD);
      rq.code = code;
      rq.row  = row;
      rq.bits = bits;
      push_request(rq);
   endtask

   task automatic draw_glyph(logic [CODE_W-1:0] code, logic [POS_W-1:0] x,
                             logic [POS_W-1:0] y, logic [COLOR_W-1:0] fore,
                             logic [COLOR_W-1:0] back);
      glyph_request_type rq;
      rq      = random_request(ACT_DRAW);
      rq.code = code;
      rq.x    = x;
      rq.y    = y;
      rq.fore = fore;
      rq.back = back;
      push_request(rq);
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (board.expected_rows.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.note_config(idx, data);
   endtask

   task automatic configure(logic [ADDR_W-1:0] base, logic [BPP_W-1:0] depth,
                            logic [LINE_W-1:0] width);
      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_register(CSR_FRAME_BASE, base);
      write_register(CSR_BITS_PER_PIXEL, ADDR_W'(depth));
      write_register(CSR_LINE_WIDTH, ADDR_W'(width));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      glyph_request_type rq;
      logic [ADDR_W-1:0] base;
      logic [BPP_W-1:0]  depth;
      logic [LINE_W-1:0] width;
      logic [CODE_W-1:0] code;
      int                phase_end;
      int                kind;
      bit                pressure_done;
      board = new();
      pressure_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      gap_odds = 2;
      for (int r = 0; r < GLYPH_ROWS; r++)
         load_row(8'hFF, GROW_W'(r), 8'hFF);
      for (int r = 0; r < GLYPH_ROWS; r++)
         load_row(8'h00, GROW_W'(r), {4'(r), ~4'(r)});
      draw_glyph(8'h00, '0, '0, '1, '0);
      configure(64'd1, 6'd32, 16'd640);
      draw_glyph(8'h00, '0, '0, '1, '0);
      draw_glyph(8'hFF, '1, '1, '0, '1);
      configure('1, 6'd8, '1);
      draw_glyph(8'h00, '1, '1, $urandom, $urandom);
      configure({$urandom, $urandom}, 6'd24, '0);
      draw_glyph(8'hFF, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);
      configure({$urandom, $urandom}, 6'd40, LINE_W'($urandom));
      draw_glyph(8'h00, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);
      configure({$urandom, $urandom}, 6'd56, LINE_W'($urandom));
      draw_glyph(8'h00, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);
      configure({$urandom, $urandom}, 6'd0, 16'd640);
      draw_glyph(8'h00, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);
      load_row(8'h00, 4'd0, FONT_W'($urandom));
      configure({$urandom, $urandom}, 6'd12, 16'd640);
      draw_glyph(8'hFF, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);
      configure({$urandom, $urandom}, 6'd63, 16'd640);
      draw_glyph(8'h00, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);
      configure({$urandom, $urandom}, 6'd16, 16'd640);
      draw_glyph(8'h00, POS_W'($urandom), POS_W'($urandom), $urandom, $urandom);

      for (int phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0:       base = '0;
            1:       base = '1;
            default: base = {$urandom, $urandom};
         endcase
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
               0:       depth = 6'd0;
               1:       depth = 6'd12;
               default: depth = 6'd63;
            endcase
         end else begin
            depth = BPP_W'(8 * $urandom_range(1, 7));
         end
         case ($urandom_range(0, 5))
            0:       width = '0;
            1:       width = '1;
            2:       width = 16'd640;
            default: width = LINE_W'($urandom);
         endcase
         if (phase == PHASES - 1) begin
            steady_tail = 1'b1;
            base  = {$urandom, $urandom} | 64'd1;
            depth = BPP_W'(8 * $urandom_range(1, 4));
         end
         configure(base, depth, width);
         gap_odds  = $urandom_range(0, 3);
         phase_end = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < phase_end) begin
            if (phase == 3 && !pressure_done && items_sent + 10 >= phase_end) begin
               wait_results_done();
               pressure_done = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
               code = CODE_W'($urandom);
               for (int r = 0; r < GLYPH_ROWS; r++)
                  load_row(code, GROW_W'(r), FONT_W'($urandom));
            end else if (kind < 20) begin
               push_request(random_request(ACT_LOAD));
            end else begin
               rq = random_request(ACT_DRAW);
               rq.code = drawable[$urandom_range(0, drawable.size() - 1)];
               push_request(rq);
            end
         end
      end

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d draws and %0d font row loads under %0d register settings.",
               draws_sent, loads_sent, settings_used);
      $display("Compared %0d rows, including disabled, wide-pixel and wrapping setups.",
               board.rows_checked);
      if (board.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/gfr_pkg.sv
rtl/core/gfr_font_store.sv
rtl/core/gfr_mac.sv
rtl/core/glyph_to_framebuffer_renderer.sv
bench/tb_glyph_to_framebuffer_renderer.sv
